@@ hw/rtl/sdc_pkg.sv @@
`timescale 1ns / 1ps
package sdc_pkg;

	localparam int COORD_BITS_DEF = 20;
	localparam int COLOR_BITS     = 8;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;

	// Register index as seen in paddr[2]; byte address 0 holds color_mode.
	localparam logic REG_COLOR_MODE = 1'b0;

	// A nonzero direction always has one component of at least floor(255 / sqrt(3)).
	localparam logic [COLOR_BITS-1:0] MIN_PEAK = 8'd147;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} top_state_t;

	typedef enum logic [2:0] {
		EN_IDLE,
		EN_SQUARE,
		EN_NORM,
		EN_INIT,
		EN_TRY,
		EN_HOLD
	} eng_state_t;

	typedef struct packed {
		logic start;
		logic line_done;
	} eng_ctl_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
		logic                  zero_length;
		logic                  line_done;
	} color_res_t;

endpackage

@@ hw/rtl/sdc_color_unit.sv @@
`timescale 1ns / 1ps
module sdc_color_unit #(
	parameter int COORD_BITS = sdc_pkg::COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sdc_pkg::eng_ctl_t      ctl,
	input  logic [COORD_BITS-1:0]  dx,
	input  logic [COORD_BITS-1:0]  dy,
	input  logic [COORD_BITS-1:0]  dz,
	output logic                   res_valid,
	input  logic                   res_ready,
	output sdc_pkg::color_res_t    res
);
	import sdc_pkg::*;

	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int NORM_W = SQ_W + 2;
	localparam int W      = SQ_W + 18;
	localparam int CNT_W  = $clog2(COORD_BITS);

	eng_state_t state_q, state_d;

	logic [COORD_BITS-1:0] d_q [3];
	logic [SQ_W-1:0]       sq_q [3];
	logic [CNT_W-1:0]      cnt_q;
	logic [1:0]            comp_q;
	logic [2:0]            bit_q;
	logic [NORM_W-1:0]     norm_q;
	logic [W-1:0]          target_q;
	logic [W-1:0]          p_q;
	logic [W-1:0]          qs_q;
	logic [W-1:0]          ns_q;
	logic [COLOR_BITS-1:0] c_q;
	logic [3*COLOR_BITS-1:0] col_q;
	logic                  zero_q;
	logic                  done_q;

	logic [W-1:0]          cand;
	logic                  fits;
	logic [SQ_W-1:0]       sq_sel;
	logic [W-1:0]          sq_ext;

	assign cand   = p_q + qs_q + ns_q;
	assign fits   = (cand <= target_q);
	assign sq_sel = (comp_q == 2'd0) ? sq_q[0] : ((comp_q == 2'd1) ? sq_q[1] : sq_q[2]);
	assign sq_ext = W'(sq_sel);

	always_comb begin
		state_d = state_q;
		case (state_q)
			EN_IDLE: begin
				if (ctl.start) begin
					state_d = EN_SQUARE;
				end
			end
			EN_SQUARE: begin
				if (cnt_q == '0) begin
					state_d = EN_NORM;
				end
			end
			EN_NORM: state_d = EN_INIT;
			EN_INIT: state_d = EN_TRY;
			EN_TRY: begin
				if (bit_q == 3'd0) begin
					state_d = (comp_q == 2'd2) ? EN_HOLD : EN_INIT;
				end
			end
			EN_HOLD: begin
				if (res_ready) begin
					state_d = EN_IDLE;
				end
			end
			default: state_d = EN_IDLE;
		endcase
	end

	always_comb begin
		res_valid       = (state_q == EN_HOLD);
		res.red         = zero_q ? '0 : col_q[3*COLOR_BITS-1:2*COLOR_BITS];
		res.green       = zero_q ? '0 : col_q[2*COLOR_BITS-1:COLOR_BITS];
		res.blue        = zero_q ? '0 : col_q[COLOR_BITS-1:0];
		res.zero_length = zero_q;
		res.line_done   = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EN_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				EN_IDLE: cnt_q <= CNT_W'(COORD_BITS - 1);
				EN_SQUARE: cnt_q <= cnt_q - 1'b1;
				EN_NORM: comp_q <= 2'd0;
				EN_INIT: bit_q <= 3'd7;
				EN_TRY: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == 3'd0) begin
						comp_q <= comp_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// One multiplier bit per cycle for the squares, one color bit per cycle for the search.
	always_ff @(posedge clk) begin
		case (state_q)
			EN_IDLE: begin
				if (ctl.start) begin
					d_q[0]  <= dx;
					d_q[1]  <= dy;
					d_q[2]  <= dz;
					sq_q[0] <= '0;
					sq_q[1] <= '0;
					sq_q[2] <= '0;
					zero_q  <= (dx == '0) && (dy == '0) && (dz == '0);
					done_q  <= ctl.line_done;
				end
			end
			EN_SQUARE: begin
				for (int i = 0; i < 3; i++) begin
					sq_q[i] <= {sq_q[i][SQ_W-2:0], 1'b0}
						+ (d_q[i][cnt_q] ? SQ_W'(d_q[i]) : SQ_W'(0));
				end
			end
			EN_NORM: begin
				norm_q <= NORM_W'(sq_q[0]) + NORM_W'(sq_q[1]) + NORM_W'(sq_q[2]);
			end
			EN_INIT: begin
				target_q <= (sq_ext << 16) - (sq_ext << 9) + sq_ext;
				p_q      <= '0;
				qs_q     <= '0;
				ns_q     <= W'(norm_q) << 14;
				c_q      <= '0;
			end
			EN_TRY: begin
				if (fits) begin
					p_q  <= cand;
					qs_q <= (qs_q >> 1) + ns_q;
				end else begin
					qs_q <= qs_q >> 1;
				end
				ns_q <= ns_q >> 2;
				c_q  <= {c_q[COLOR_BITS-2:0], fits};
				if (bit_q == 3'd0) begin
					col_q <= {col_q[2*COLOR_BITS-1:0], c_q[COLOR_BITS-2:0], fits};
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/streamline_direction_colorer_core.sv @@
`timescale 1ns / 1ps
// Streamline direction colorer.
// Points enter on the s_ channel, one transfer per point, with s_tlast on the
// last point of a line. Colors leave on the m_ channel: tdata holds red, green
// and blue, tuser flags a zero-length direction and tlast marks the last color
// of a line. The APB port holds color_mode at address 0 (0 = local direction,
// 1 = one color per line from its endpoints).
// A point yields zero, one or two colors. Each color is computed in steps: an
// issue step, a shift-add squaring of the three components over the coordinate
// bits, a norm step, per color component a setup step and eight search steps
// against the squared norm, and a handoff step.
// s_tready is high while no color is being computed. A finished color sits in
// the output register, so the next point is taken while it waits; if the
// receiver stalls longer, the color unit holds its next color until the output
// register frees. Reset clears the line history, the output valid flag and
// color_mode.
module streamline_direction_colorer_core #(
	parameter  int COORD_BITS = sdc_pkg::COORD_BITS_DEF,
	localparam int IN_W       = ((3 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,   // point_x, point_y, point_z, zero fill
	input  logic                            s_tlast,   // end_of_line
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [3*sdc_pkg::COLOR_BITS-1:0] m_tdata,  // red, green, blue
	output logic                            m_tuser,   // zero_length
	output logic                            m_tlast,   // line_done
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sdc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sdc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import sdc_pkg::*;

	top_state_t state_q, state_d;

	logic                  mode_q;
	logic [1:0]            seen_q;
	logic [COORD_BITS-1:0] older_q [3];
	logic [COORD_BITS-1:0] newer_q [3];
	logic [COORD_BITS-1:0] first_q [3];
	logic [COORD_BITS-1:0] ja_q [3];
	logic [COORD_BITS-1:0] jb_q [3];
	logic                  has_b_q;
	logic                  sel_q;

	logic                  s_fire;
	logic                  has_a;
	logic [COORD_BITS-1:0] pt [3];
	logic [COORD_BITS-1:0] ba [3];
	logic [COORD_BITS-1:0] bb [3];
	logic [COORD_BITS:0]   diff_a [3];
	logic [COORD_BITS:0]   diff_b [3];
	logic [COORD_BITS:0]   mag_a [3];
	logic [COORD_BITS:0]   mag_b [3];

	eng_ctl_t              eng_ctl;
	logic                  eng_valid;
	logic                  eng_ready;
	logic                  eng_done;
	color_res_t            eng_res;
	color_res_t            out_q;
	logic                  m_tvalid_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLOR_MODE) ? APB_DATA_W'(mode_q) : '0;

	assign s_fire = s_tvalid && s_tready;
	assign has_a  = !mode_q && (seen_q != 2'd0);

	for (genvar i = 0; i < 3; i++) begin : g_diff
		assign pt[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
		assign ba[i] = (seen_q == 2'd1) ? newer_q[i] : older_q[i];
		assign bb[i] = (seen_q == 2'd0) ? pt[i] : (mode_q ? first_q[i] : newer_q[i]);
		assign diff_a[i] = {pt[i][COORD_BITS-1], pt[i]} - {ba[i][COORD_BITS-1], ba[i]};
		assign diff_b[i] = {pt[i][COORD_BITS-1], pt[i]} - {bb[i][COORD_BITS-1], bb[i]};
		assign mag_a[i] = diff_a[i][COORD_BITS] ? (~diff_a[i] + (COORD_BITS+1)'(1)) : diff_a[i];
		assign mag_b[i] = diff_b[i][COORD_BITS] ? (~diff_b[i] + (COORD_BITS+1)'(1)) : diff_b[i];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire && (has_a || s_tlast)) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (eng_done) begin
					state_d = (!sel_q && has_b_q) ? ST_ISSUE : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready          = (state_q == ST_IDLE);
		eng_ctl.start     = (state_q == ST_ISSUE);
		eng_ctl.line_done = sel_q;
	end

	assign eng_ready = !m_tvalid_q || m_tready;
	assign eng_done  = eng_valid && eng_ready;

	sdc_color_unit #(
		.COORD_BITS (COORD_BITS)
	) u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (eng_ctl),
		.dx        (sel_q ? jb_q[0] : ja_q[0]),
		.dy        (sel_q ? jb_q[1] : ja_q[1]),
		.dz        (sel_q ? jb_q[2] : ja_q[2]),
		.res_valid (eng_valid),
		.res_ready (eng_ready),
		.res       (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= 1'b0;
			seen_q     <= 2'd0;
			has_b_q    <= 1'b0;
			sel_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				older_q[i] <= '0;
				newer_q[i] <= '0;
				first_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && pready && (paddr[2] == REG_COLOR_MODE)) begin
				mode_q <= pwdata[0];
			end
			if (s_fire) begin
				has_b_q <= s_tlast;
				sel_q   <= !has_a;
				if (seen_q == 2'd0) begin
					for (int i = 0; i < 3; i++) begin
						first_q[i] <= pt[i];
					end
				end
				if (s_tlast) begin
					seen_q <= 2'd0;
				end else begin
					for (int i = 0; i < 3; i++) begin
						older_q[i] <= newer_q[i];
						newer_q[i] <= pt[i];
					end
					if (seen_q != 2'd2) begin
						seen_q <= seen_q + 1'b1;
					end
				end
			end else if ((state_q == ST_WAIT) && eng_done) begin
				sel_q <= 1'b1;
			end
			if (eng_done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			for (int i = 0; i < 3; i++) begin
				ja_q[i] <= mag_a[i][COORD_BITS-1:0];
				jb_q[i] <= mag_b[i][COORD_BITS-1:0];
			end
		end
		if (eng_done) begin
			out_q <= eng_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.blue, out_q.green, out_q.red};
	assign m_tuser  = out_q.zero_length;
	assign m_tlast  = out_q.line_done;

endmodule

@@ hw/rtl/sdc_checker.sv @@
`timescale 1ns / 1ps
module sdc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [3*sdc_pkg::COLOR_BITS-1:0] m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);
	import sdc_pkg::*;

	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;

	assign red   = m_tdata[COLOR_BITS-1:0];
	assign green = m_tdata[2*COLOR_BITS-1:COLOR_BITS];
	assign blue  = m_tdata[3*COLOR_BITS-1:2*COLOR_BITS];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == '0))
		else $error("zero-length direction with a nonblack color");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (red >= MIN_PEAK) || (green >= MIN_PEAK) || (blue >= MIN_PEAK))
		else $error("nonzero direction not scaled to full length");

endmodule

bind streamline_direction_colorer_core sdc_checker u_sdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
